/* src/tag_sighting_table_core_defines.svh */
// ---------------------------------------------------------------------------
// Tag sighting table assertion macros
// Shared concurrent assertion forms for the tag sighting table, clocked on
// the rising edge and switched off while reset is held.
// ---------------------------------------------------------------------------
`ifndef TAG_SIGHTING_TABLE_CORE_DEFINES_SVH
`define TAG_SIGHTING_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TST_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tag sighting table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tag sighting table: next-cycle check failed");

`endif

/* src/tst_pkg.sv */
// ---------------------------------------------------------------------------
// Tag sighting table package
// Sizes, result codes, the entry layout, controller/datapath command and
// status structs, and the saturating level counter update.
// ---------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    // Table geometry and flush limit.
    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_RESULTS - 1);

    // Counter limits and the highest accepted strength level.
    localparam logic [3:0] COUNT_MAX = 4'd15;
    localparam logic [3:0] TOP_LEVEL = 4'd7;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // Sighting status codes.
    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_ADDED   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Sources for the result register.
    localparam logic [1:0] SRC_STATUS = 2'd0;
    localparam logic [1:0] SRC_PEND   = 2'd1;
    localparam logic [1:0] SRC_EMPTY  = 2'd2;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  building;
        logic [31:0] counts;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_issue;
        logic       wr_add;
        logic       wr_update;
        logic       take;
        logic       pend_clr;
        logic       emit;
        logic [1:0] emit_src;
        logic [1:0] emit_status;
        logic       emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush;
        logic lvl_bad;
        logic tag_zero;
        logic hit;
        logic empty;
        logic idx_last;
        logic pend_valid;
        logic cnt_limit;
        logic out_free;
    } dp_status_t;

    // Raise the 4-bit counter of one level, saturating at its maximum.
    function automatic logic [31:0] raise_level(input logic [31:0] counts,
                                                input logic [2:0] lvl);
        logic [31:0] res;
        logic [3:0]  nib;
        res = counts;
        for (int n = 0; n < 8; n++) begin
            nib = counts[4*n +: 4];
            if ((3'(n) == lvl) && (nib != COUNT_MAX)) begin
                res[4*n +: 4] = nib + 4'd1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/tst_ctrl.sv */
// ---------------------------------------------------------------------------
// Tag sighting table controller
// Sequences the table scan for sightings and flushes, one entry read and
// one evaluation step per table entry.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_ctrl
    import tst_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t sts,
    output dp_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_src    = SRC_STATUS;
        cmd.emit_status = ST_UPDATED;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                // Sightings with a bad level or the empty tag finish without a table scan.
                if (sts.flush) begin
                    state_next = S_READ;
                end else if (sts.lvl_bad || sts.tag_zero) begin
                    if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_src    = SRC_STATUS;
                        cmd.emit_status = sts.lvl_bad ? ST_RANGE : ST_DROPPED;
                        state_next      = S_IDLE;
                    end
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL: begin
                if (!sts.flush) begin
                    // Sighting: stop at the first matching or empty entry.
                    if (sts.hit || sts.empty) begin
                        if (sts.out_free) begin
                            cmd.wr_update   = sts.hit;
                            cmd.wr_add      = !sts.hit;
                            cmd.emit        = 1'b1;
                            cmd.emit_src    = SRC_STATUS;
                            cmd.emit_status = sts.hit ? ST_UPDATED : ST_ADDED;
                            state_next      = S_IDLE;
                        end
                    end else if (sts.idx_last) begin
                        if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_src    = SRC_STATUS;
                            cmd.emit_status = ST_DROPPED;
                            state_next      = S_IDLE;
                        end
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end else if (!sts.empty) begin
                    // Flush: the held entry goes out once a newer one is found.
                    if (!sts.pend_valid || sts.out_free) begin
                        cmd.take      = 1'b1;
                        cmd.emit      = sts.pend_valid;
                        cmd.emit_src  = SRC_PEND;
                        cmd.emit_last = 1'b0;
                        if (sts.cnt_limit || sts.idx_last) begin
                            state_next = S_FINISH;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                end else if (sts.idx_last) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_FINISH: begin
                // Final flush result: the held entry, or the empty marker.
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = sts.pend_valid ? SRC_PEND : SRC_EMPTY;
                    cmd.emit_last = 1'b1;
                    cmd.pend_clr  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/tst_dp.sv */
// ---------------------------------------------------------------------------
// Tag sighting table datapath
// Input capture, entry memory with occupancy flags, the held flush entry,
// the scan index and flush counter, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_dp
    import tst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       sts,
    input  wire logic        s_action,
    input  wire logic [15:0] s_tag_id,
    input  wire logic [15:0] s_pos_x,
    input  wire logic [15:0] s_pos_y,
    input  wire logic [7:0]  s_building,
    input  wire logic [3:0]  s_strength,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [1:0]       m_status,
    output logic [15:0]      m_out_tag_id,
    output logic [15:0]      m_out_x,
    output logic [15:0]      m_out_y,
    output logic [7:0]       m_out_building,
    output logic [31:0]      m_level_counts,
    output logic             m_last
);

    // Captured input item.
    logic        action_reg;
    logic [15:0] tag_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [7:0]  bld_reg;
    logic [3:0]  lvl_reg;

    // Scan position and number of entries taken by the current flush.
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Entry memory, occupancy flags and registered read.
    entry_t                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    entry_t                 rd_reg;
    logic                   rd_valid_reg;

    // Entry held back during a flush until its successor is known.
    entry_t pend_reg;
    logic   pend_valid_reg;

    // Result register.
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [1:0]  kind_reg;
    logic [1:0]  status_reg;
    logic [15:0] otag_reg;
    logic [15:0] ox_reg;
    logic [15:0] oy_reg;
    logic [7:0]  obld_reg;
    logic [31:0] ocnt_reg;
    logic        last_reg;

    logic        out_free;
    logic [31:0] upd_counts;
    logic [31:0] add_counts;
    entry_t      wr_data;
    logic        wr_en;

    assign out_free   = !m_valid_reg || m_ready;
    assign upd_counts = raise_level(rd_reg.counts, lvl_reg[2:0]);
    assign add_counts = raise_level(32'd0, lvl_reg[2:0]);

    // Status towards the controller.
    always_comb begin
        sts.flush      = action_reg;
        sts.lvl_bad    = (lvl_reg > TOP_LEVEL);
        sts.tag_zero   = (tag_reg == 16'd0);
        sts.hit        = rd_valid_reg && (rd_reg.tag == tag_reg);
        sts.empty      = !rd_valid_reg;
        sts.idx_last   = (idx_reg == IDX_LAST);
        sts.pend_valid = pend_valid_reg;
        sts.cnt_limit  = (cnt_reg == CNT_LIMIT);
        sts.out_free   = out_free;
    end

    // Input capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= s_action;
            tag_reg    <= s_tag_id;
            x_reg      <= s_pos_x;
            y_reg      <= s_pos_y;
            bld_reg    <= s_building;
            lvl_reg    <= s_strength;
        end
    end

    // Scan index and flush counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end else begin
                if (cmd.idx_inc) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (cmd.take) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Write data: a new entry, or the read entry with its counter raised.
    always_comb begin
        wr_en = cmd.wr_add || cmd.wr_update;
        if (cmd.wr_add) begin
            wr_data.tag      = tag_reg;
            wr_data.x        = x_reg;
            wr_data.y        = y_reg;
            wr_data.building = bld_reg;
            wr_data.counts   = add_counts;
        end else begin
            wr_data        = rd_reg;
            wr_data.counts = upd_counts;
        end
    end

    // Entry memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_reg <= mem[idx_reg];
        end
    end

    // Occupancy flags and registered read of the flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_add) begin
                valid_reg[idx_reg] <= 1'b1;
            end else if (cmd.take) begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.rd_issue) begin
                rd_valid_reg <= valid_reg[idx_reg];
            end
        end
    end

    // Held flush entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.take) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.pend_clr) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pend_reg <= rd_reg;
        end
    end

    // Result valid: set on a new result, cleared once the transfer completes.
    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            unique case (cmd.emit_src)
                SRC_STATUS: begin
                    kind_reg   <= KIND_STATUS;
                    status_reg <= cmd.emit_status;
                    otag_reg   <= tag_reg;
                    ox_reg     <= 16'd0;
                    oy_reg     <= 16'd0;
                    obld_reg   <= 8'd0;
                    if (cmd.emit_status == ST_UPDATED) begin
                        ocnt_reg <= upd_counts;
                    end else if (cmd.emit_status == ST_ADDED) begin
                        ocnt_reg <= add_counts;
                    end else begin
                        ocnt_reg <= 32'd0;
                    end
                    last_reg   <= 1'b1;
                end
                SRC_PEND: begin
                    kind_reg   <= KIND_ENTRY;
                    status_reg <= ST_UPDATED;
                    otag_reg   <= pend_reg.tag;
                    ox_reg     <= pend_reg.x;
                    oy_reg     <= pend_reg.y;
                    obld_reg   <= pend_reg.building;
                    ocnt_reg   <= pend_reg.counts;
                    last_reg   <= cmd.emit_last;
                end
                default: begin
                    kind_reg   <= KIND_EMPTY;
                    status_reg <= ST_UPDATED;
                    otag_reg   <= 16'd0;
                    ox_reg     <= 16'd0;
                    oy_reg     <= 16'd0;
                    obld_reg   <= 8'd0;
                    ocnt_reg   <= 32'd0;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_status       = status_reg;
    assign m_out_tag_id   = otag_reg;
    assign m_out_x        = ox_reg;
    assign m_out_y        = oy_reg;
    assign m_out_building = obld_reg;
    assign m_level_counts = ocnt_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

/* src/tag_sighting_table_core.sv */
// ---------------------------------------------------------------------------
// Tag sighting table core
// Records radio-tag sightings into a scanned entry table with per-level
// saturating counters, and flushes occupied entries on request.
// ---------------------------------------------------------------------------
//
// Channel   Ports        Moves
// input     s_valid/rdy  one sighting or flush request per transfer
// result    m_valid/rdy  one status, flushed entry or empty marker
//
// A sighting scans entries up to the first match or empty entry, at most
// TABLE_DEPTH of them. A flush scans the whole table, plus result stalls.
// Each scanned entry takes a read step and then an evaluation step, set by the
// single registered read port of the entry memory.
// Occupancy is held in flip-flops cleared by reset, so no clearing pass runs.
// A stalled result holds the scan only when a further result must be loaded.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tag_sighting_table_core_defines.svh"

module tag_sighting_table_core
    import tst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [15:0] s_tag_id,
    input  wire logic [15:0] s_pos_x,
    input  wire logic [15:0] s_pos_y,
    input  wire logic [7:0]  s_building,
    input  wire logic [3:0]  s_strength,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [1:0]       m_status,
    output logic [15:0]      m_out_tag_id,
    output logic [15:0]      m_out_x,
    output logic [15:0]      m_out_y,
    output logic [7:0]       m_out_building,
    output logic [31:0]      m_level_counts,
    output logic             m_last
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    // Scan sequencer.
    tst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table storage and result path.
    tst_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_action       (s_action),
        .s_tag_id       (s_tag_id),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_building     (s_building),
        .s_strength     (s_strength),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_status       (m_status),
        .m_out_tag_id   (m_out_tag_id),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_building (m_out_building),
        .m_level_counts (m_level_counts),
        .m_last         (m_last)
    );

    // A new result is only loaded when the previous one has gone or is leaving.
    `TST_ASSERT_SAME(a_emit_free, aclk, aresetn, cmd.emit, (!m_valid || m_ready))

    // The table is written only together with the status result it causes.
    `TST_ASSERT_SAME(a_write_emits, aclk, aresetn, (cmd.wr_add || cmd.wr_update), cmd.emit)

    // After an input transfer the block is busy in the following cycle.
    `TST_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready), !s_ready)

    // The empty marker is always the only, and so the final, flush result.
    `TST_ASSERT_SAME(a_empty_last, aclk, aresetn, (m_valid && (m_kind == KIND_EMPTY)), m_last)

endmodule

`default_nettype wire
